>>> hdl/sxd_pkg.sv
// Shared types and codes for the STX/ETX escape deframer.
package sxd_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 16;
  localparam int KindW = 2;
  localparam int ErrW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Result kinds (m_tuser)
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_END     = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [ErrW-1:0] ERR_NO_START        = 2'd0;
  localparam logic [ErrW-1:0] ERR_BAD_ESCAPE      = 2'd1;
  localparam logic [ErrW-1:0] ERR_UNESCAPED_START = 2'd2;
  localparam logic [ErrW-1:0] ERR_OVERFLOW        = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START_CODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_END_CODE    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ESCAPE_CODE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
    logic [ByteW-1:0] escape_code;
    logic [LenW-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  message_length;
    logic [ErrW-1:0]  error_code;
  } res_t;

endpackage

>>> hdl/sxd_core.sv
// Deframer state and per-byte decode: mode, escape flag, previous byte, count.
module sxd_core import sxd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [ByteW-1:0] raw_byte,
  input  cfg_t             cfg,
  output res_t             res
);

  typedef enum logic [1:0] {
    SEARCH   = 2'd0,
    EXPECT   = 2'd1,
    ASSEMBLE = 2'd2
  } mode_t;

  mode_t            mode, mode_next;
  logic             escape_pending, escape_pending_next;
  logic [ByteW-1:0] previous_byte;
  logic [LenW-1:0]  byte_count, byte_count_next;

  logic            naked_start;
  logic            is_special;
  logic            do_store;
  logic            do_fail;
  logic [ErrW-1:0] fail_code;

  assign naked_start = (raw_byte == cfg.start_code) && (previous_byte != cfg.escape_code);
  assign is_special  = (raw_byte == cfg.start_code) || (raw_byte == cfg.end_code) ||
                       (raw_byte == cfg.escape_code);

  always_comb begin
    mode_next           = mode;
    escape_pending_next = escape_pending;
    byte_count_next     = byte_count;
    do_store            = 1'b0;
    do_fail             = 1'b0;
    fail_code           = ERR_NO_START;
    res                 = '0;

    unique case (mode)
      ASSEMBLE: begin
        priority if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (is_special) begin
            do_store = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_ESCAPE;
          end
        end else if (raw_byte == cfg.end_code) begin
          res.valid          = 1'b1;
          res.kind           = KIND_END;
          res.message_length = byte_count;
          mode_next          = EXPECT;
          byte_count_next    = '0;
        end else if (raw_byte == cfg.escape_code) begin
          escape_pending_next = 1'b1;
        end else if (raw_byte == cfg.start_code) begin
          do_fail   = 1'b1;
          fail_code = ERR_UNESCAPED_START;
        end else begin
          do_store = 1'b1;
        end
      end
      EXPECT: begin
        if (naked_start) begin
          mode_next           = ASSEMBLE;
          escape_pending_next = 1'b0;
          byte_count_next     = '0;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_START;
        end
      end
      default: begin
        // searching; unused mode code behaves the same
        if (naked_start) begin
          mode_next           = ASSEMBLE;
          escape_pending_next = 1'b0;
          byte_count_next     = '0;
        end else begin
          mode_next = SEARCH;
        end
      end
    endcase

    // count never passes max_length, so 16 bits hold it
    if (do_store) begin
      if (byte_count >= cfg.max_length) begin
        do_fail   = 1'b1;
        fail_code = ERR_OVERFLOW;
      end else begin
        byte_count_next  = byte_count + LenW'(1);
        res.valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = raw_byte;
      end
    end

    if (do_fail) begin
      mode_next           = SEARCH;
      escape_pending_next = 1'b0;
      byte_count_next     = '0;
      res                 = '0;
      res.valid           = 1'b1;
      res.kind            = KIND_ERROR;
      res.error_code      = fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= SEARCH;
      escape_pending <= 1'b0;
      previous_byte  <= '0;
      byte_count     <= '0;
    end else if (fire) begin
      mode           <= mode_next;
      escape_pending <= escape_pending_next;
      previous_byte  <= raw_byte;
      byte_count     <= byte_count_next;
    end
  end

endmodule

>>> hdl/stx_etx_escape_deframer.sv
// Top level of the STX/ETX escape deframer: config, input and result registers.
//
//   channel  dir  payload                                      transfer when
//   s_axis   in   tdata[7:0] raw_byte                          s_tvalid & s_tready
//   m_axis   out  tuser kind; tdata payload/length/error       m_tvalid & m_tready
//   cfg      in   cfg_index selects register, cfg_data value   cfg_we
//
// One byte per cycle sustained while m_tready stays high. A byte is held in the
// input register, is decoded by sxd_core, and its result (if any) lands in the
// output register, which drives m_tvalid and the m_axis fields.
// rst is synchronous; it restores the default codes and searching mode.
// A stalled m_axis holds the output register; the input register then
// fills and s_tready drops. Bytes that yield no result still take one slot.
module stx_etx_escape_deframer import sxd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // slave stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] raw_byte
  // master stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,   // [7:0] payload_byte, [23:8] message_length,
                                         // [25:24] error_code, [31:26] zero
  output logic [KindW-1:0]    m_tuser,   // [1:0] kind
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code  <= 8'd2;
      cfg.end_code    <= 8'd3;
      cfg.escape_code <= 8'd27;
      cfg.max_length  <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_CODE:  cfg.start_code  <= cfg_data[ByteW-1:0];
        REG_END_CODE:    cfg.end_code    <= cfg_data[ByteW-1:0];
        REG_ESCAPE_CODE: cfg.escape_code <= cfg_data[ByteW-1:0];
        REG_MAX_LENGTH:  cfg.max_length  <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             advance;   // decode the held byte this cycle
  res_t             res;

  // output register
  logic             out_valid;
  logic [KindW-1:0] out_kind;
  logic [ByteW-1:0] out_payload;
  logic [LenW-1:0]  out_length;
  logic [ErrW-1:0]  out_error;

  // held byte moves on when the output slot is free or drains this cycle
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  sxd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .raw_byte (in_byte),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind    <= res.kind;
      out_payload <= res.payload_byte;
      out_length  <= res.message_length;
      out_error   <= res.error_code;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_error, out_length, out_payload};

endmodule

>>> verif/stx_etx_escape_deframer_test.sv
// Self-checking testbench for the STX/ETX escape deframer.
module stx_etx_escape_deframer_test;
  import sxd_pkg::*;

  // Run limit in cycles. Roughly 530 bytes go in, and the limit leaves wide room
  // for random gaps on either side and for one long receiver hold.
  localparam int CycleLimit  = 200_000;
  localparam int HoldCycles  = 60;   // long receiver hold-off in the pressure phase
  localparam int DrainCycles = 8;    // extra wait before the final verdict

  // Deframer modes, mirrored in the scoreboard's own state.
  typedef enum logic [1:0] {
    SEARCHING,
    EXPECTING,
    ASSEMBLING
  } framer_mode_e;

  // Test phases. The phase sets the idle pattern of the sender and the receiver.
  typedef enum logic [2:0] {
    PH_RESET,
    PH_DIRECTED,
    PH_FREE,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_IDLE,
    PH_HOLD
  } phase_e;

  // One result transfer: kind plus the fields that tdata carries.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] payload;
    logic [LenW-1:0]  length;
    logic [ErrW-1:0]  err;
  } deframe_event_t;

  // Scoreboard: it tracks framing state and register values, and it queues
  // the result, if any, that each accepted raw byte should produce.
  class deframe_scoreboard;
    logic [ByteW-1:0] start_code  = 8'd2;
    logic [ByteW-1:0] end_code    = 8'd3;
    logic [ByteW-1:0] escape_code = 8'd27;
    logic [LenW-1:0]  max_length  = 16'd4096;

    framer_mode_e     mode          = SEARCHING;
    bit               escape_open   = 1'b0;
    logic [ByteW-1:0] last_raw      = 8'd0;
    logic [16:0]      payload_count = 17'd0;

    deframe_event_t   pending_events[$];
    int               failures = 0;

    function bit is_code(logic [ByteW-1:0] b);
      return b == start_code || b == end_code || b == escape_code;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_START_CODE:  start_code  = data[7:0];
        REG_END_CODE:    end_code    = data[7:0];
        REG_ESCAPE_CODE: escape_code = data[7:0];
        REG_MAX_LENGTH:  max_length  = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void post(logic [KindW-1:0] kind, logic [ByteW-1:0] payload,
                       logic [LenW-1:0] length, logic [ErrW-1:0] err);
      deframe_event_t ev;
      ev.kind    = kind;
      ev.payload = payload;
      ev.length  = length;
      ev.err     = err;
      pending_events.push_back(ev);
    endfunction

    // Errors drop any message in progress and go back to the start search.
    function void abort(logic [ErrW-1:0] err);
      mode          = SEARCHING;
      escape_open   = 1'b0;
      payload_count = '0;
      post(KIND_ERROR, '0, '0, err);
    endfunction

    function void keep_payload(logic [ByteW-1:0] b);
      if (payload_count >= {1'b0, max_length}) begin
        abort(ERR_OVERFLOW);
      end else begin
        payload_count = payload_count + 17'd1;
        post(KIND_PAYLOAD, b, '0, '0);
      end
    endfunction

    function void absorb_byte(logic [ByteW-1:0] b);
      bit naked_start;
      naked_start = (b == start_code) && (last_raw != escape_code);
      last_raw    = b;
      case (mode)
        ASSEMBLING: begin
          if (escape_open) begin
            escape_open = 1'b0;
            if (!is_code(b)) abort(ERR_BAD_ESCAPE);
            else keep_payload(b);
          end else if (b == end_code) begin
            post(KIND_END, '0, payload_count[15:0], '0);
            mode          = EXPECTING;
            payload_count = '0;
          end else if (b == escape_code) begin
            escape_open = 1'b1;
          end else if (b == start_code) begin
            abort(ERR_UNESCAPED_START);
          end else begin
            keep_payload(b);
          end
        end
        EXPECTING: begin
          if (naked_start) begin
            mode          = ASSEMBLING;
            escape_open   = 1'b0;
            payload_count = '0;
          end else begin
            abort(ERR_NO_START);
          end
        end
        default: begin
          if (naked_start) begin
            mode          = ASSEMBLING;
            escape_open   = 1'b0;
            payload_count = '0;
          end
        end
      endcase
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_event(logic [KindW-1:0] kind, logic [31:0] data);
      deframe_event_t want;
      if (pending_events.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none actual kind %0h data %h",
                 $time, kind, data);
        return;
      end
      want = pending_events.pop_front();
      compare("kind", want.kind, kind);
      compare("payload_byte", want.payload, data[7:0]);
      compare("message_length", want.length, data[23:8]);
      compare("error_code", want.err, data[25:24]);
      compare("tdata padding", '0, data[31:26]);
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata   = 8'd0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [31:0]         m_tdata;
  logic [KindW-1:0]    m_tuser;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  deframe_scoreboard sb = new();
  phase_e            phase = PH_RESET;
  int                gap_pct = 0;      // sender idle chance per cycle, in percent
  int                bytes_sent = 0;
  int                held = 0;
  int                cycle_count = 0;

  stx_etx_escape_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hang or a result that never arrives ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: it checks each result transfer and drives tready for the phase.
  // In the hold phase tready stays low for a long stretch once. The input
  // side then backs up and s_tready must drop.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_event(m_tuser, m_tdata);
    if (phase == PH_HOLD && held < HoldCycles) begin
      held     <= held + 1;
      m_tready <= 1'b0;
    end else if (phase == PH_RECV_STALLS) begin
      m_tready <= ($urandom_range(99) >= 78);
    end else if (phase == PH_BOTH_IDLE) begin
      m_tready <= ($urandom_range(99) >= 34);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One raw byte over the input stream. Random idle cycles come first. The
  // byte goes to the scoreboard only on the edge where the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.absorb_byte(b);
    bytes_sent++;
  endtask

  // Payload content. About a third of the bytes are one of the codes.
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(7))
      0:       return sb.start_code;
      1:       return sb.end_code;
      default: return ($urandom_range(99) < 10) ? sb.escape_code : 8'($urandom_range(255));
    endcase
  endfunction

  // A payload byte that equals a code is sent with the escape code before it.
  task automatic send_payload(input logic [7:0] b);
    if (sb.is_code(b)) send_byte(sb.escape_code);
    send_byte(b);
  endtask

  task automatic send_frame(input int len);
    send_byte(sb.start_code);
    repeat (len) send_payload(pick_payload());
    send_byte(sb.end_code);
  endtask

  // Random traffic. Most of it is well-formed frames. The rest is line noise,
  // bad escapes, raw start codes inside a message, and, when max_length is at most 16, frames that overflow.
  task automatic send_traffic(input int n);
    int         stop_at;
    int         r;
    int         len;
    logic [7:0] b;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r   = $urandom_range(99);
      len = $urandom_range(8);
      if (r < 65) begin
        send_frame(len);
      end else if (r < 75) begin
        send_byte(8'($urandom_range(255)));
      end else if (r < 84) begin
        send_byte(sb.start_code);
        repeat (len) send_payload(pick_payload());
        do b = 8'($urandom_range(255)); while (sb.is_code(b));
        send_byte(sb.escape_code);
        send_byte(b);
      end else if (r < 92) begin
        send_byte(sb.start_code);
        repeat (len) send_payload(pick_payload());
        send_byte(sb.start_code);
      end else begin
        send_frame((sb.max_length <= 16) ? sb.max_length + $urandom_range(1, 2) : len);
      end
    end
  endtask

  // Stop sending and wait until every expected result has arrived. Then keep
  // the input idle for any trailing byte that produces no result.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic write_regs(input logic [7:0] start_val, input logic [7:0] end_val,
                            input logic [7:0] escape_val, input logic [15:0] max_val);
    write_reg(REG_START_CODE, 16'(start_val));
    write_reg(REG_END_CODE, 16'(end_val));
    write_reg(REG_ESCAPE_CODE, 16'(escape_val));
    write_reg(REG_MAX_LENGTH, max_val);
    cfg_we <= 1'b0;
  endtask

  task automatic set_phase(input phase_e p);
    phase <= p;
    case (p)
      PH_SEND_GAPS: gap_pct = 78;
      PH_BOTH_IDLE: gap_pct = 34;
      default:      gap_pct = 0;
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, using the codes in force after reset.
    set_phase(PH_DIRECTED);
    send_byte(8'hFF);                 // noise while searching is dropped
    send_byte(8'h00);
    send_byte(sb.escape_code);        // a start right after an escape does not open
    send_byte(sb.start_code);
    send_byte(sb.start_code);         // this one opens
    send_byte(8'h00);
    send_byte(8'hFF);
    send_payload(sb.start_code);      // escaped codes become payload
    send_payload(sb.end_code);
    send_payload(sb.escape_code);
    send_byte(8'h5A);
    send_byte(sb.end_code);           // message end, length 6
    send_byte(8'h41);                 // garbage where a start is expected
    send_byte(sb.start_code);
    send_byte(sb.escape_code);
    send_byte(8'h41);                 // bad escape
    send_byte(sb.start_code);
    send_byte(8'h10);
    send_byte(sb.start_code);         // unescaped start inside a message
    send_frame(0);                    // empty message
    send_frame(1);                    // start right after an end
    settle();

    // max_length of 1, start and end codes at the byte extremes, no idling.
    write_regs(8'h00, 8'hFF, 8'h7E, 16'd1);
    set_phase(PH_FREE);
    send_byte(sb.start_code);
    send_byte(8'h11);
    send_byte(8'h22);                 // overflow on the second payload byte
    send_frame(1);                    // exactly at max_length
    send_traffic(100);
    settle();

    // Largest max_length, sender idles often.
    write_regs(8'h7E, 8'h7D, 8'h7F, 16'hFFFF);
    set_phase(PH_SEND_GAPS);
    send_traffic(100);
    settle();

    // Start and end share a value, receiver stalls often.
    write_regs(8'hAA, 8'hAA, 8'h55, 16'd5);
    set_phase(PH_RECV_STALLS);
    send_traffic(100);
    settle();

    // Start and escape share a value, both sides idle.
    write_regs(8'hFF, 8'h00, 8'hFF, 16'd8);
    set_phase(PH_BOTH_IDLE);
    send_traffic(100);
    settle();

    // Back to the reset codes. The receiver holds off while bytes keep coming.
    write_regs(8'h02, 8'h03, 8'h1B, 16'd4096);
    set_phase(PH_HOLD);
    send_traffic(100);
    settle();

    repeat (DrainCycles) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sxd_pkg.sv
hdl/sxd_core.sv
hdl/stx_etx_escape_deframer.sv
verif/stx_etx_escape_deframer_test.sv
